// File: rtl/core/pbld_pkg.sv
package pbld_pkg;

  // mode codes
  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_DEBOUNCE  = 2'd1;
  localparam logic [1:0] MODE_DOWN      = 2'd2;
  localparam logic [1:0] MODE_POWER_OFF = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TENTHS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_ENABLE = 1'd1;
  localparam int unsigned CFG_DATA_W = 10;

  // fixed widths
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SINCE_W = 11;
  localparam int unsigned HOLD_W  = 18;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

  // parameter defaults
  localparam int unsigned DEF_DEBOUNCE_TICKS    = 20;
  localparam int unsigned DEF_RATE_LIMIT_TICKS  = 1500;
  localparam int unsigned DEF_HOLD_MARGIN_TICKS = 20;
  localparam int unsigned DEF_TICKS_PER_TENTH   = 100;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] hold_tenths;
    logic                  escape_enable;
  } cfg_t;

  typedef struct packed {
    logic       power_pulse;
    logic       escape_pulse;
    logic       backlight_off;
    logic [1:0] mode_now;
  } result_t;

endpackage

// File: rtl/core/pbld_fsm.sv
module pbld_fsm
  import pbld_pkg::*;
#(
  parameter int unsigned DEBOUNCE_TICKS    = DEF_DEBOUNCE_TICKS,
  parameter int unsigned RATE_LIMIT_TICKS  = DEF_RATE_LIMIT_TICKS,
  parameter int unsigned HOLD_MARGIN_TICKS = DEF_HOLD_MARGIN_TICKS,
  parameter int unsigned TICKS_PER_TENTH   = DEF_TICKS_PER_TENTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    level,
  input  cfg_t    cfg,
  output result_t res
);

  logic [1:0]         mode, mode_next;
  logic [COUNT_W-1:0] countdown, countdown_next;
  logic [SINCE_W-1:0] since, since_next;
  logic               previous_level;

  logic               press_edge, release_edge;
  logic               expired;
  logic [COUNT_W-1:0] count_dec;
  logic [HOLD_W-1:0]  hold_sum;
  logic [COUNT_W-1:0] hold_len;
  logic               reported;

  // hold length, saturated to the countdown width
  assign hold_sum = HOLD_W'(cfg.hold_tenths) * HOLD_W'(TICKS_PER_TENTH)
                  + HOLD_W'(HOLD_MARGIN_TICKS);
  assign hold_len = (hold_sum > HOLD_W'(COUNT_MAX)) ? COUNT_MAX : hold_sum[COUNT_W-1:0];

  assign press_edge   = previous_level && !level;
  assign release_edge = !previous_level && level;
  assign expired      = (countdown <= COUNT_W'(1));
  assign count_dec    = expired ? '0 : countdown - COUNT_W'(1);

  always_comb begin
    mode_next         = mode;
    countdown_next    = countdown;
    reported          = 1'b0;
    res.power_pulse   = 1'b0;
    res.escape_pulse  = 1'b0;
    res.backlight_off = 1'b0;
    unique case (mode)
      MODE_IDLE: begin
        if (press_edge) begin
          countdown_next = COUNT_W'(DEBOUNCE_TICKS);
          mode_next      = MODE_DEBOUNCE;
        end
      end
      MODE_DEBOUNCE: begin
        countdown_next = count_dec;
        if (expired) begin
          if (!level) begin
            countdown_next = hold_len;
            mode_next      = MODE_DOWN;
          end else begin
            mode_next = MODE_IDLE;
          end
        end
      end
      MODE_DOWN: begin
        if (release_edge) begin
          countdown_next   = '0;
          mode_next        = MODE_IDLE;
          res.escape_pulse = cfg.escape_enable;
        end else begin
          countdown_next = count_dec;
          if (expired) begin
            if (!level) begin
              reported          = (since > SINCE_W'(RATE_LIMIT_TICKS));
              res.power_pulse   = reported;
              res.backlight_off = 1'b1;
              mode_next         = MODE_POWER_OFF;
            end else begin
              mode_next = MODE_IDLE;
            end
          end
        end
      end
      MODE_POWER_OFF: begin
        if (release_edge) begin
          mode_next = MODE_IDLE;
        end
      end
    endcase
    res.mode_now = mode_next;
  end

  // saturating tick count since the last power report
  assign since_next = reported ? '0 :
                      (since == SINCE_MAX) ? since : since + SINCE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      countdown      <= '0;
      since          <= '0;
      previous_level <= 1'b1;
    end else if (step) begin
      mode           <= mode_next;
      countdown      <= countdown_next;
      since          <= since_next;
      previous_level <= level;
    end
  end

`ifndef ASSERT_OFF
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    step && res.power_pulse |=> since == '0)
    else $error("power report did not clear the tick count");

  a_backlight_on_entry: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_DOWN && res.mode_now == MODE_POWER_OFF |-> res.backlight_off)
    else $error("power-off entered without backlight command");

  a_debounce_bound: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DEBOUNCE |-> countdown <= COUNT_W'(DEBOUNCE_TICKS))
    else $error("debounce countdown out of range");

  a_escape_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.escape_pulse |=> mode == MODE_IDLE && !previous_level == 1'b0)
    else $error("escape without return to idle");
`endif

endmodule

// File: rtl/core/power_button_long_press_detector_core.sv
// long-press power button detector: one word per millisecond tick carries the
// sampled active-low button level, and each accepted word yields exactly one
// result word with power, escape and backlight-off pulses plus the mode after
// the tick (0 idle, 1 debounce, 2 down, 3 power-off). a press in idle starts a
// debounce; if still held at its end the hold countdown of
// hold_tenths * TICKS_PER_TENTH + HOLD_MARGIN_TICKS ticks runs, and an early
// release pulses escape when escape_enable is set. hold expiry enters
// power-off with backlight off and a power pulse, the latter only when more
// than RATE_LIMIT_TICKS ticks have gone by since the last report. throughput
// is one word per clock while out_ready holds the result side open; the input
// register takes each accepted word and the result register then takes the
// state update for it once the result register is free. configuration is
// written through cfg_write, cfg_index and cfg_data and should only change
// while no word is in flight.
module power_button_long_press_detector_core
  import pbld_pkg::*;
#(
  parameter int unsigned DEBOUNCE_TICKS    = DEF_DEBOUNCE_TICKS,
  parameter int unsigned RATE_LIMIT_TICKS  = DEF_RATE_LIMIT_TICKS,
  parameter int unsigned HOLD_MARGIN_TICKS = DEF_HOLD_MARGIN_TICKS,
  parameter int unsigned TICKS_PER_TENTH   = DEF_TICKS_PER_TENTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  button_level,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  power_pulse,
  output logic                  escape_pulse,
  output logic                  backlight_off,
  output logic [1:0]            mode_now
);

  cfg_t    cfg;
  logic    s1_valid;
  logic    s1_level;
  logic    out_free;
  logic    step;
  result_t res;
  result_t res_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HOLD_TENTHS:   cfg.hold_tenths   <= cfg_data;
        CFG_ESCAPE_ENABLE: cfg.escape_enable <= cfg_data[0];
      endcase
    end
  end

  // result register is free when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;
  // input register moves on whenever the result register can take its word
  assign in_ready = !s1_valid || out_free;
  // one state update per word, in order
  assign step     = s1_valid && out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level <= button_level;
    end
  end

  // state machine and tick counters
  pbld_fsm #(
    .DEBOUNCE_TICKS   (DEBOUNCE_TICKS),
    .RATE_LIMIT_TICKS (RATE_LIMIT_TICKS),
    .HOLD_MARGIN_TICKS(HOLD_MARGIN_TICKS),
    .TICKS_PER_TENTH  (TICKS_PER_TENTH)
  ) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .level(s1_level),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign power_pulse   = res_q.power_pulse;
  assign escape_pulse  = res_q.escape_pulse;
  assign backlight_off = res_q.backlight_off;
  assign mode_now      = res_q.mode_now;

endmodule

// File: test/long_press_checker.sv
module long_press_checker
  import pbld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  button_level,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  power_pulse,
  input  logic                  escape_pulse,
  input  logic                  backlight_off,
  input  logic [1:0]            mode_now,
  output int                    failures,
  output int                    pending
);

  result_t              expected_words[$];
  cfg_t                 cfg_q;
  logic [1:0]           mode_q;
  logic [COUNT_W-1:0]   countdown_q;
  logic [SINCE_W-1:0]   since_q;
  logic                 prev_level_q;

  // true on the step where the countdown runs out, else one tick down
  function automatic logic count_expired();
    if (countdown_q <= 1) begin
      countdown_q = '0;
      return 1'b1;
    end
    countdown_q = countdown_q - 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [COUNT_W-1:0] hold_length();
    int unsigned h;
    h = cfg_q.hold_tenths * DEF_TICKS_PER_TENTH + DEF_HOLD_MARGIN_TICKS;
    return (h > COUNT_MAX) ? COUNT_MAX : COUNT_W'(h);
  endfunction

  // one millisecond tick of the detector
  function automatic result_t advance_tick(input logic level);
    result_t r;
    logic    press_seen;
    logic    release_seen;
    logic    reported;
    r            = '0;
    reported     = 1'b0;
    press_seen   = prev_level_q & ~level;
    release_seen = ~prev_level_q & level;
    case (mode_q)
      MODE_IDLE: begin
        if (press_seen) begin
          countdown_q = COUNT_W'(DEF_DEBOUNCE_TICKS);
          mode_q      = MODE_DEBOUNCE;
        end
      end
      MODE_DEBOUNCE: begin
        if (count_expired()) begin
          if (!level) begin
            countdown_q = hold_length();
            mode_q      = MODE_DOWN;
          end else begin
            mode_q = MODE_IDLE;
          end
        end
      end
      MODE_DOWN: begin
        // release beats expiry on the same tick
        if (release_seen) begin
          countdown_q    = '0;
          mode_q         = MODE_IDLE;
          r.escape_pulse = cfg_q.escape_enable;
        end else if (count_expired()) begin
          if (!level) begin
            reported        = (since_q > DEF_RATE_LIMIT_TICKS);
            r.power_pulse   = reported;
            r.backlight_off = 1'b1;
            mode_q          = MODE_POWER_OFF;
          end else begin
            mode_q = MODE_IDLE;
          end
        end
      end
      default: begin
        if (release_seen) mode_q = MODE_IDLE;
      end
    endcase
    if (reported) since_q = '0;
    else if (since_q != SINCE_MAX) since_q = since_q + 1'b1;
    prev_level_q = level;
    r.mode_now   = mode_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      expected_words.delete();
      cfg_q        = '0;
      mode_q       = MODE_IDLE;
      countdown_q  = '0;
      since_q      = '0;
      prev_level_q = 1'b1;
      failures     = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_HOLD_TENTHS:   cfg_q.hold_tenths   = cfg_data;
          CFG_ESCAPE_ENABLE: cfg_q.escape_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected, mode_now %0d", mode_now);
          failures++;
        end else begin
          want = expected_words.pop_front();
          check_field("power_pulse", 2'(want.power_pulse), 2'(power_pulse));
          check_field("escape_pulse", 2'(want.escape_pulse), 2'(escape_pulse));
          check_field("backlight_off", 2'(want.backlight_off), 2'(backlight_off));
          check_field("mode_now", want.mode_now, mode_now);
        end
      end
      if (in_valid && in_ready) expected_words.push_back(advance_tick(button_level));
    end
    pending = expected_words.size();
  end

endmodule

// File: test/testbench.sv
module testbench;
  import pbld_pkg::*;

  // cycles with no word moving on either side before the run is called dead
  localparam int WATCHDOG_LIMIT = 2000;
  // rough number of input words for the whole run
  localparam int TOTAL_WORDS    = 1850;
  localparam int PHASES         = 6;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_HOLD_TENTHS;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  button_level = 1'b1;
  logic                  out_ready    = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  power_pulse;
  logic                  escape_pulse;
  logic                  backlight_off;
  logic [1:0]            mode_now;

  int failures;
  int pending;
  bit calm         = 1'b0;  // no idling on either side once set
  int words_sent   = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  int hold_cur     = 20;    // hold length of the current setting, for shaping presses

  // random-phase register settings, the last one runs without idling
  int unsigned tenths_set [PHASES] = '{0, 1, 0, 2, 3, 1};
  bit          escape_set [PHASES] = '{1, 0, 0, 1, 0, 1};

  always #6 clk = ~clk;

  power_button_long_press_detector_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_level  (button_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .power_pulse   (power_pulse),
    .escape_pulse  (escape_pulse),
    .backlight_off (backlight_off),
    .mode_now      (mode_now)
  );

  long_press_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_level  (button_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .power_pulse   (power_pulse),
    .escape_pulse  (escape_pulse),
    .backlight_off (backlight_off),
    .mode_now      (mode_now),
    .failures      (failures),
    .pending       (pending)
  );

  // result side: ready drops in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && !rst && $urandom_range(0, 6) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: counts cycles in which no word is accepted on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one tick word; valid stays high across back-to-back words
  task automatic send_word(input logic level);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    button_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_run(input logic level, input int n);
    repeat (n) send_word(level);
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // registers are only touched with the block drained
  task automatic set_regs(input int unsigned tenths, input bit esc);
    drain();
    write_reg(CFG_HOLD_TENTHS, CFG_DATA_W'(tenths));
    write_reg(CFG_ESCAPE_ENABLE, CFG_DATA_W'(esc));
    hold_cur = tenths * DEF_TICKS_PER_TENTH + DEF_HOLD_MARGIN_TICKS;
    if (hold_cur > COUNT_MAX) hold_cur = COUNT_MAX;
  endtask

  // press edge, debounce window (optionally bouncing), level at debounce expiry,
  // then hold_ticks pressed ticks and a release when the debounce was passed
  task automatic press_cycle(input int hold_ticks, input bit noisy, input logic settle);
    send_word(1'b0);
    repeat (DEF_DEBOUNCE_TICKS - 1) send_word(noisy ? ($urandom_range(0, 1) != 0) : 1'b0);
    send_word(settle);
    if (!settle) begin
      send_run(1'b0, hold_ticks);
      send_word(1'b1);
    end
  endtask

  // well-formed press with hold picked around the hold length:
  // early release, release on the expiry tick, or into power-off
  task automatic random_press();
    int h;
    case ($urandom_range(0, 3))
      0:       h = $urandom_range(0, hold_cur - 2);
      1:       h = hold_cur - 1;
      2:       h = hold_cur;
      default: h = hold_cur + $urandom_range(1, 20);
    endcase
    send_run(1'b1, $urandom_range(1, 5));
    press_cycle(h, $urandom_range(0, 1) != 0, $urandom_range(0, 5) == 0);
  endtask

  // random traffic until the running word count reaches stop
  task automatic random_phase(input int stop);
    while (words_sent < stop) begin
      case ($urandom_range(0, 9))
        // noise on the pin, may leave the block mid-sequence
        0:       repeat ($urandom_range(1, 8)) send_word($urandom_range(0, 1) != 0);
        // long released stretch so the report rate limit opens up
        1:       send_run(1'b1, $urandom_range(100, 600));
        default: random_press();
      endcase
    end
  endtask

  initial begin
    int base;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: shortest hold, escape reporting on
    set_regs(0, 1'b1);
    send_run(1'b1, 2);                // idle, released
    press_cycle(0, 1'b1, 1'b1);       // bouncing press, gone by debounce expiry
    press_cycle(5, 1'b0, 1'b0);       // early release, escape word
    set_regs(0, 1'b0);
    press_cycle(5, 1'b0, 1'b0);       // early release, escape masked
    press_cycle(19, 1'b0, 1'b0);      // release on the very tick the hold expires
    press_cycle(30, 1'b0, 1'b0);      // power-off too soon after reset, report held back

    // extremes: saturated hold length and a large unsaturated one, early release
    set_regs(1023, 1'b1);
    press_cycle(150, 1'b0, 1'b0);
    set_regs(600, 1'b1);
    press_cycle(150, 1'b0, 1'b0);

    // random phases share what is left of the word budget;
    // each register change also drains the pipe
    base = words_sent;
    for (int i = 0; i < PHASES; i++) begin
      set_regs(tenths_set[i], escape_set[i]);
      if (i == PHASES - 1) calm = 1'b1;
      random_phase(base + (i + 1) * (TOTAL_WORDS - base) / PHASES);
    end

    drain();
    // allow for any stray word after the last expected one
    repeat (8) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pbld_pkg.sv
rtl/core/pbld_fsm.sv
rtl/core/power_button_long_press_detector_core.sv
test/long_press_checker.sv
test/testbench.sv
